/* rtl/srrw_pkg.sv */
// shared types, constants and helpers for the selective-repeat receive window
`default_nettype none

package srrw_pkg;

    localparam int WINDOW      = 16;
    localparam int SEQ_W       = 16;
    localparam int SLOT_OUT_W  = 4;
    localparam int BITMAP_W    = 16;
    localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RELEASE_CAP = (WINDOW < 16) ? WINDOW : 16;
    localparam int CNT_W       = $clog2(RELEASE_CAP + 1);
    localparam int Q_DEPTH     = 2;
    localparam int Q_IDX_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [CNT_W-1:0]   CAP_LIMIT = CNT_W'(RELEASE_CAP);
    localparam logic [SLOT_W:0]    SLOT_MOD  = (SLOT_W + 1)'(WINDOW);
    localparam logic [SEQ_W:0]     WIN_SPAN  = (SEQ_W + 1)'(WINDOW);
    localparam logic [SEQ_W-1:0]   SEQ_TOP   = {SEQ_W{1'b1}};

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RELEASE,
        ST_ACK
    } back_state_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
    } pkt_t;

    typedef struct packed {
        logic                  kind;
        logic [SEQ_W-1:0]      seq_value;
        logic [SLOT_OUT_W-1:0] slot;
        logic [BITMAP_W-1:0]   bitmap;
        logic                  accepted;
        logic                  last;
    } res_t;

    // (a + b) mod WINDOW for a, b already below WINDOW
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SLOT_MOD)
            s = s - SLOT_MOD;
        return s[SLOT_W-1:0];
    endfunction

    // low bits of a slot number as carried on the result
    function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+SLOT_OUT_W-1:0] t;
        t = {{SLOT_OUT_W{1'b0}}, s};
        return t[SLOT_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/selective_repeat_receive_window.sv */
// top level of the selective-repeat receive window
//
// input channel: in_valid/in_ready with seq_number and crc_ok. an item with
// crc_ok low is taken and dropped with no results. a good item goes into a
// two-entry queue, so the input can stay ready while the back end works.
// output channel: out_valid/out_ready with kind, seq_value, slot, bitmap,
// accepted and last. each good item gives zero to sixteen release results
// (kind 0, in sequence order) and then one acknowledgement (kind 1, last 1)
// carrying the new base and the bitmap of buffered slots from the base up.
// steps: the item is written into the queue, the back end checks it and marks
// the window, releases each buffered slot in order from the base, ends the
// release run and sends the acknowledgement, then takes the next item; an
// item that falls outside the window goes straight from the check to the
// acknowledgement.
// the release sequencer walks one slot per cycle and handles one item at a
// time; the result register holds while out_ready is low and the sequencer
// waits on it, while the queue keeps taking items until it is full.
// reset clears the base to zero and all slot valid flags, empties the queue
// and drops any pending result.
`default_nettype none

module selective_repeat_receive_window
    import srrw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SEQ_W-1:0]      seq_number,
    input  wire logic                  crc_ok,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       kind,
    output logic [SEQ_W-1:0]           seq_value,
    output logic [SLOT_OUT_W-1:0]      slot,
    output logic [BITMAP_W-1:0]        bitmap,
    output logic                       accepted,
    output logic                       last
);

    logic pkt_valid;
    logic pkt_ready;
    pkt_t pkt;
    res_t res;

    srrw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .seq_number (seq_number),
        .crc_ok     (crc_ok),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt        (pkt)
    );

    srrw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign kind      = res.kind;
    assign seq_value = res.seq_value;
    assign slot      = res.slot;
    assign bitmap    = res.bitmap;
    assign accepted  = res.accepted;
    assign last      = res.last;

endmodule

`default_nettype wire

/* rtl/srrw_front.sv */
// front end: takes packets, drops bad-crc ones, queues the rest for the back end
`default_nettype none

module srrw_front
    import srrw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [SEQ_W-1:0] seq_number,
    input  wire logic             crc_ok,
    output logic                  pkt_valid,
    input  wire logic             pkt_ready,
    output pkt_t                  pkt
);

    pkt_t               q_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               push;
    logic               pop;

    assign in_ready  = (cnt_reg < Q_CNT_W'(Q_DEPTH));
    assign pkt_valid = (cnt_reg != '0);
    assign pkt       = q_mem[rd_ptr_reg];

    // a bad-crc item is taken and dropped here
    assign push = in_valid && in_ready && crc_ok;
    assign pop  = pkt_valid && pkt_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= '{seq: seq_number};
    end

endmodule

`default_nettype wire

/* rtl/srrw_back.sv */
// back end: window state, in-order release sequencer and result register
`default_nettype none

module srrw_back
    import srrw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic pkt_valid,
    output logic      pkt_ready,
    input  wire pkt_t pkt,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      res
);

    back_state_t         state_reg, state_next;
    logic [SEQ_W-1:0]    base_reg, base_next;
    logic [SLOT_W-1:0]   base_slot_reg, base_slot_next;
    logic [WINDOW-1:0]   valid_reg, valid_next;
    logic                acc_reg, acc_next;
    logic [CNT_W-1:0]    rel_cnt_reg, rel_cnt_next;
    logic                out_valid_reg, out_valid_next;
    res_t                res_reg, res_next;

    logic                out_free;
    logic                rel_go;
    logic                pop;
    logic                rel_fire;
    logic                ack_fire;
    logic [SEQ_W:0]      offset;
    logic                in_win;
    logic [SLOT_W-1:0]   ins_idx;
    logic [BITMAP_W-1:0] bitmap_now;

    assign out_free = !out_valid_reg || out_ready;
    assign rel_go   = valid_reg[base_slot_reg] && (rel_cnt_reg < CAP_LIMIT);

    // window check without 16-bit wrap on the upper bound
    assign offset  = {1'b0, pkt.seq} - {1'b0, base_reg};
    assign in_win  = (pkt.seq >= base_reg) && (offset < WIN_SPAN);
    assign ins_idx = slot_add(base_slot_reg, offset[SLOT_W-1:0]);

    always_comb
    begin
        bitmap_now = '0;
        for (int i = 0; i < BITMAP_W; i++)
        begin
            if (i < RELEASE_CAP)
                bitmap_now[i] = valid_reg[slot_add(base_slot_reg, SLOT_W'(i))];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pkt_valid)
                    state_next = in_win ? ST_RELEASE : ST_ACK;
            end
            ST_RELEASE:
            begin
                if (out_free && !rel_go)
                    state_next = ST_ACK;
            end
            ST_ACK:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pkt_ready = 1'b0;
        rel_fire  = 1'b0;
        ack_fire  = 1'b0;
        case (state_reg)
            ST_IDLE:    pkt_ready = 1'b1;
            ST_RELEASE: rel_fire  = out_free && rel_go;
            ST_ACK:     ack_fire  = out_free;
            default:    pkt_ready = 1'b0;
        endcase
    end

    assign pop = pkt_valid && pkt_ready;

    always_comb
    begin
        base_next      = base_reg;
        base_slot_next = base_slot_reg;
        valid_next     = valid_reg;
        acc_next       = acc_reg;
        rel_cnt_next   = rel_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;

        if (pop)
        begin
            acc_next     = in_win && !valid_reg[ins_idx];
            rel_cnt_next = '0;
            if (in_win)
                valid_next[ins_idx] = 1'b1;
        end

        if (rel_fire)
        begin
            valid_next[base_slot_reg] = 1'b0;
            base_next      = base_reg + 1'b1;
            // base wraps at the top of the number space, slot restarts at zero
            base_slot_next = (base_reg == SEQ_TOP) ? '0
                                                   : slot_add(base_slot_reg, SLOT_W'(1));
            rel_cnt_next   = rel_cnt_reg + 1'b1;
            out_valid_next = 1'b1;
            res_next       = '{kind:      KIND_RELEASE,
                               seq_value: base_reg,
                               slot:      slot_out(base_slot_reg),
                               bitmap:    '0,
                               accepted:  acc_reg,
                               last:      1'b0};
        end

        if (ack_fire)
        begin
            out_valid_next = 1'b1;
            res_next       = '{kind:      KIND_ACK,
                               seq_value: base_reg,
                               slot:      '0,
                               bitmap:    bitmap_now,
                               accepted:  acc_reg,
                               last:      1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            base_slot_reg <= '0;
            valid_reg     <= '0;
            acc_reg       <= 1'b0;
            rel_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            base_slot_reg <= base_slot_next;
            valid_reg     <= valid_next;
            acc_reg       <= acc_next;
            rel_cnt_reg   <= rel_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    a_release_advances_base: assert property (@(posedge clk) disable iff (!rst_n)
        rel_fire |=> (base_reg == $past(base_reg) + 1'b1))
        else $error("release did not advance the window base");

    a_release_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rel_cnt_reg <= CAP_LIMIT)
        else $error("release count beyond cap");

    a_base_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, base_slot_reg} < SLOT_MOD)
        else $error("base slot out of window range");

    a_last_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.last) |-> (res_reg.kind == KIND_ACK))
        else $error("last flag on a release result");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pkt_ready)
        else $error("packet taken while an item is still in progress");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for the selective-repeat receive window
module testbench
    import srrw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_GOOD  = 160;
    localparam int MAX_REPORTS  = 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [SEQ_W-1:0]      seq_number;
    logic                  crc_ok;
    logic                  out_valid;
    logic                  out_ready;
    logic                  kind;
    logic [SEQ_W-1:0]      seq_value;
    logic [SLOT_OUT_W-1:0] slot;
    logic [BITMAP_W-1:0]   bitmap;
    logic                  accepted;
    logic                  last;

    // own copy of the receive window
    logic [SEQ_W-1:0] rx_base;
    logic             rx_slot_full [WINDOW];

    res_t pending_results [$];
    res_t seen_result;
    res_t wanted_result;
    int   error_count = 0;
    int   cycle_count = 0;
    int   stall_left  = 0;
    bit   steady      = 1'b0;

    selective_repeat_receive_window i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .seq_number (seq_number),
        .crc_ok     (crc_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .seq_value  (seq_value),
        .slot       (slot),
        .bitmap     (bitmap),
        .accepted   (accepted),
        .last       (last)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // expected results of one packet, appended in order
    function automatic void predict_packet(input logic [SEQ_W-1:0] seq, input logic good);
        int unsigned  idx;
        int unsigned  s;
        int           n;
        logic         acc;
        res_t         r;
        logic [BITMAP_W-1:0] bm;
        n   = 0;
        acc = 1'b0;
        bm  = '0;
        if (!good)
            return;
        if ({1'b0, seq} >= {1'b0, rx_base} &&
            {1'b0, seq} < {1'b0, rx_base} + (SEQ_W + 1)'(WINDOW))
        begin
            idx = seq % WINDOW;
            if (!rx_slot_full[idx])
            begin
                rx_slot_full[idx] = 1'b1;
                acc = 1'b1;
            end
            while (n < RELEASE_CAP && rx_slot_full[rx_base % WINDOW])
            begin
                s = rx_base % WINDOW;
                r = '0;
                r.kind      = KIND_RELEASE;
                r.seq_value = rx_base;
                r.slot      = s[SLOT_OUT_W-1:0];
                r.accepted  = acc;
                pending_results.push_back(r);
                rx_slot_full[s] = 1'b0;
                rx_base = rx_base + 1'b1;
                n++;
            end
        end
        for (int i = 0; i < RELEASE_CAP; i++)
            if (rx_slot_full[(int'(rx_base) + i) % WINDOW])
                bm[i] = 1'b1;
        r = '0;
        r.kind      = KIND_ACK;
        r.seq_value = rx_base;
        r.bitmap    = bm;
        r.accepted  = acc;
        r.last      = 1'b1;
        pending_results.push_back(r);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic pause_input(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic good);
        in_valid   <= 1'b1;
        seq_number <= seq;
        crc_ok     <= good;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_packet(seq, good);
        pause_input(pick_gap());
    endtask

    task automatic wait_until_drained();
        pause_input(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic report_error(input string what);
        string want_text;
        string got_text;
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            want_text = $sformatf("kind=%0d seq=%0d slot=%0d bitmap=%h acc=%0d last=%0d",
                                  wanted_result.kind, wanted_result.seq_value,
                                  wanted_result.slot, wanted_result.bitmap,
                                  wanted_result.accepted, wanted_result.last);
            got_text  = $sformatf("kind=%0d seq=%0d slot=%0d bitmap=%h acc=%0d last=%0d",
                                  seen_result.kind, seen_result.seq_value,
                                  seen_result.slot, seen_result.bitmap,
                                  seen_result.accepted, seen_result.last);
            $display("%0s: want %0s, got %0s", what, want_text, got_text);
        end
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (steady || $urandom_range(0, 99) < 80)
            out_ready <= 1'b1;
        else
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                      : $urandom_range(0, 3);
            out_ready  <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_result.kind      = kind;
            seen_result.seq_value = seq_value;
            seen_result.slot      = slot;
            seen_result.bitmap    = bitmap;
            seen_result.accepted  = accepted;
            seen_result.last      = last;
            if (pending_results.size() == 0)
            begin
                wanted_result = 'x;
                report_error("unexpected result");
            end
            else
            begin
                wanted_result = pending_results.pop_front();
                if (seen_result.kind      !== wanted_result.kind      ||
                    seen_result.seq_value !== wanted_result.seq_value ||
                    seen_result.slot      !== wanted_result.slot      ||
                    seen_result.bitmap    !== wanted_result.bitmap    ||
                    seen_result.accepted  !== wanted_result.accepted  ||
                    seen_result.last      !== wanted_result.last)
                    report_error("mismatch");
            end
        end
    end

    task automatic test_bad_crc();
        send_packet(16'd0, 1'b0);
        send_packet(SEQ_TOP, 1'b0);
    endtask

    task automatic test_in_order();
        send_packet(rx_base, 1'b1);
        send_packet(rx_base, 1'b1);
    endtask

    task automatic test_out_of_order();
        send_packet(rx_base + 16'd2, 1'b1);
        send_packet(rx_base + 16'd1, 1'b1);
        send_packet(rx_base, 1'b1);
    endtask

    task automatic test_duplicate();
        send_packet(rx_base + 16'd1, 1'b1);
        send_packet(rx_base + 16'd1, 1'b1);
        send_packet(rx_base + 16'd1, 1'b0);
    endtask

    task automatic test_outside_window();
        send_packet(rx_base - 16'd1, 1'b1);
        send_packet(rx_base + SEQ_W'(WINDOW), 1'b1);
        send_packet(SEQ_TOP, 1'b1);
    endtask

    // fill the whole window behind the base, then the base releases the lot
    task automatic test_release_cap();
        logic [SEQ_W-1:0] start;
        start = rx_base;
        for (int i = WINDOW - 1; i >= 1; i--)
            if (!rx_slot_full[(int'(start) + i) % WINDOW])
                send_packet(start + SEQ_W'(i), 1'b1);
        send_packet(start, 1'b1);
        send_packet(rx_base + SEQ_W'(WINDOW - 1), 1'b1);
    endtask

    task automatic test_random_traffic();
        int good_sent;
        int r;
        int off;
        int o;
        int k;
        good_sent = 0;
        k = 0;
        while (good_sent < RANDOM_GOOD)
        begin
            steady = (k % 60) >= 48;
            k++;
            if (k == 100)
                wait_until_drained();
            r = $urandom_range(0, 99);
            if (r < 8)
                send_packet(SEQ_W'($urandom), 1'b0);
            else
            begin
                good_sent++;
                if (r < 14)
                    send_packet(SEQ_W'($urandom), 1'b1);
                else if (r < 20)
                    send_packet(rx_base - SEQ_W'($urandom_range(1, 4)), 1'b1);
                else if (r < 25)
                    send_packet(rx_base + SEQ_W'(WINDOW + $urandom_range(0, 3)), 1'b1);
                else if (r < 35)
                begin
                    // repeat a packet already buffered, if there is one
                    off = 0;
                    o = $urandom_range(0, WINDOW - 1);
                    for (int j = 0; j < WINDOW; j++)
                        if (rx_slot_full[(int'(rx_base) + o + j) % WINDOW])
                        begin
                            off = (o + j) % WINDOW;
                            break;
                        end
                    send_packet(rx_base + SEQ_W'(off), 1'b1);
                end
                else if (r < 47)
                    send_packet(rx_base, 1'b1);
                else
                    send_packet(rx_base + SEQ_W'($urandom_range(0, WINDOW - 1)), 1'b1);
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rx_base = '0;
        for (int i = 0; i < WINDOW; i++)
            rx_slot_full[i] = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        seq_number <= '0;
        crc_ok     <= 1'b0;
        out_ready  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bad_crc();
        test_in_order();
        test_out_of_order();
        test_duplicate();
        test_outside_window();
        test_release_cap();
        wait_until_drained();
        test_random_traffic();
        wait_until_drained();

        if (pending_results.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
